>>> hw/rtl/ovd_pkg.sv
`default_nettype none

package ovd_pkg;

    localparam int MAX_LEVELS = 10;
    localparam int LVL_W      = 4;
    localparam int COORD_W    = 10;
    localparam int OCT_W      = 3;
    localparam int ST_W       = 3;

    localparam logic [LVL_W-1:0] EDGE_LEVELS_RST = LVL_W'(6);
    localparam logic [LVL_W-1:0] MAX_LVL         = LVL_W'(MAX_LEVELS);
    localparam logic [OCT_W-1:0] OCT_LAST        = '1;

    localparam logic [ST_W-1:0] ST_LEAF         = 3'd0;
    localparam logic [ST_W-1:0] ST_LAST_LEAF    = 3'd1;
    localparam logic [ST_W-1:0] ST_TRAILING     = 3'd2;
    localparam logic [ST_W-1:0] ST_TRUNCATED    = 3'd3;
    localparam logic [ST_W-1:0] ST_BRANCH_VOXEL = 3'd4;

    typedef logic [LVL_W-1:0]   t_lvl;
    typedef logic [OCT_W-1:0]   t_oct;
    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord          leaf_x;
        t_coord          leaf_y;
        t_coord          leaf_z;
        t_lvl            leaf_depth;
        logic            leaf_value;
        logic [ST_W-1:0] status;
        logic            last;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/ovd_tok_if.sv
`default_nettype none

interface ovd_tok_if;
    logic valid;
    logic ready;
    logic token_bit;
    logic stream_end;

    modport source (output valid, output token_bit, output stream_end, input ready);
    modport sink (input valid, input token_bit, input stream_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ovd_leaf_if.sv
`default_nettype none

interface ovd_leaf_if;
    import ovd_pkg::*;

    logic            valid;
    logic            ready;
    t_coord          leaf_x;
    t_coord          leaf_y;
    t_coord          leaf_z;
    t_lvl            leaf_depth;
    logic            leaf_value;
    logic [ST_W-1:0] status;
    logic            last;

    modport source (
        output valid, output leaf_x, output leaf_y, output leaf_z, output leaf_depth,
        output leaf_value, output status, output last, input ready
    );
    modport sink (
        input valid, input leaf_x, input leaf_y, input leaf_z, input leaf_depth,
        input leaf_value, input status, input last, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/ovd_walker.sv
`default_nettype none

module ovd_walker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire ovd_pkg::t_lvl i_cfg_wdata,
    input  wire logic         i_take,
    input  wire logic         i_token_bit,
    input  wire logic         i_stream_end,
    output logic              o_res_valid,
    output ovd_pkg::t_res     o_res
);
    import ovd_pkg::*;

    t_lvl r_edge_levels;
    t_oct r_stack [MAX_LEVELS];
    t_lvl r_depth;
    logic r_awaiting;

    t_oct n_stack [MAX_LEVELS];
    t_lvl n_depth;
    logic n_awaiting;

    t_lvl                  lvl;
    logic [MAX_LEVELS-1:0] raw_x;
    logic [MAX_LEVELS-1:0] raw_y;
    logic [MAX_LEVELS-1:0] raw_z;
    t_lvl                  shift;
    logic                  found;
    t_lvl                  adv_idx;
    logic                  done;
    logic                  to_root;

    assign lvl   = (r_edge_levels > MAX_LVL) ? MAX_LVL : r_edge_levels;
    assign shift = MAX_LVL - lvl;

    always_comb begin
        raw_x = '0;
        raw_y = '0;
        raw_z = '0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (k < int'(r_depth) && k < int'(lvl)) begin
                raw_x[MAX_LEVELS-1-k] = r_stack[k][2];
                raw_y[MAX_LEVELS-1-k] = r_stack[k][1];
                raw_z[MAX_LEVELS-1-k] = r_stack[k][0];
            end
        end
    end

    always_comb begin
        found   = 1'b0;
        adv_idx = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (!found && i < int'(r_depth) && r_stack[i] != OCT_LAST) begin
                found   = 1'b1;
                adv_idx = LVL_W'(i);
            end
        end
        done = !found;
    end

    always_comb begin
        n_stack     = r_stack;
        n_depth     = r_depth;
        n_awaiting  = r_awaiting;
        to_root     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_awaiting) begin
            o_res_valid      = 1'b1;
            o_res.leaf_x     = COORD_W'(raw_x >> shift);
            o_res.leaf_y     = COORD_W'(raw_y >> shift);
            o_res.leaf_z     = COORD_W'(raw_z >> shift);
            o_res.leaf_depth = r_depth;
            o_res.leaf_value = i_token_bit;
            o_res.last       = done || i_stream_end;
            if (done) begin
                o_res.status = i_stream_end ? ST_LAST_LEAF : ST_TRAILING;
            end else begin
                o_res.status = i_stream_end ? ST_TRUNCATED : ST_LEAF;
            end
            n_awaiting = 1'b0;
            for (int j = 0; j < MAX_LEVELS; j++) begin
                if (LVL_W'(j) == adv_idx) begin
                    n_stack[j] = r_stack[j] + OCT_W'(1);
                end else if (LVL_W'(j) > adv_idx) begin
                    n_stack[j] = '0;
                end
            end
            n_depth = adv_idx + LVL_W'(1);
            to_root = o_res.last;
        end else if (i_token_bit && r_depth >= lvl) begin
            o_res_valid  = 1'b1;
            o_res.status = ST_BRANCH_VOXEL;
            o_res.last   = 1'b1;
            to_root      = 1'b1;
        end else if (i_stream_end) begin
            o_res_valid  = 1'b1;
            o_res.status = ST_TRUNCATED;
            o_res.last   = 1'b1;
            to_root      = 1'b1;
        end else if (!i_token_bit) begin
            n_awaiting = 1'b1;
        end else begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
                if (LVL_W'(j) == r_depth) begin
                    n_stack[j] = '0;
                end
            end
            n_depth = r_depth + LVL_W'(1);
        end
        if (to_root) begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
                n_stack[j] = '0;
            end
            n_depth    = '0;
            n_awaiting = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_levels <= EDGE_LEVELS_RST;
            r_depth       <= '0;
            r_awaiting    <= 1'b0;
            for (int j = 0; j < MAX_LEVELS; j++) begin
                r_stack[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_edge_levels <= i_cfg_wdata;
            end
            if (i_take) begin
                r_depth    <= n_depth;
                r_awaiting <= n_awaiting;
                r_stack    <= n_stack;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ovd_out_reg.sv
`default_nettype none

module ovd_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire ovd_pkg::t_res i_res,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic               o_free,
    output ovd_pkg::t_res      o_res
);
    import ovd_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/octree_voxel_decoder_core.sv
// Octree voxel decoder: parses a preorder octree bit stream, one bit per beat.
// Input channel i_tok carries token_bit and stream_end; a beat is taken when
// valid and ready are both high. Output channel o_leaf carries one leaf beat
// (origin x/y/z, depth, value, status, last) for a leaf value bit, or an
// error beat with zero leaf fields for a truncated stream or a branch at
// single-voxel size. Branch and leaf-marker bits give no output beat.
// Timing: a result beat is valid in the cycle after the input beat causing it.
// Throughput: one input beat per cycle while the single output register is
// free; octant stack, origin build and next-sibling search are combinational.
// Configuration: i_cfg_we with i_cfg_wdata writes edge_levels (log2 of the
// cube edge, values above 10 act as 10); write it only while idle.
// Reset (synchronous, active low) clears the stack to the root, sets
// edge_levels to 6 and empties the output register.
// Receiver stall: the output register holds its beat while o_leaf.ready is
// low, and i_tok.ready drops until that beat is taken.
`default_nettype none

module octree_voxel_decoder_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire ovd_pkg::t_lvl i_cfg_wdata,
    ovd_tok_if.sink            i_tok,
    ovd_leaf_if.source         o_leaf
);
    import ovd_pkg::*;

    logic free;
    logic take;
    logic res_valid;
    t_res res;
    t_res out_res;
    logic out_valid;

    assign i_tok.ready = free;
    assign take        = i_tok.valid && free;

    ovd_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_take       (take),
        .i_token_bit  (i_tok.token_bit),
        .i_stream_end (i_tok.stream_end),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    ovd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .i_ready (o_leaf.ready),
        .o_valid (out_valid),
        .o_free  (free),
        .o_res   (out_res)
    );

    assign o_leaf.valid      = out_valid;
    assign o_leaf.leaf_x     = out_res.leaf_x;
    assign o_leaf.leaf_y     = out_res.leaf_y;
    assign o_leaf.leaf_z     = out_res.leaf_z;
    assign o_leaf.leaf_depth = out_res.leaf_depth;
    assign o_leaf.leaf_value = out_res.leaf_value;
    assign o_leaf.status     = out_res.status;
    assign o_leaf.last       = out_res.last;

endmodule

`default_nettype wire
